// File: src/rsp_packet_deframer_rx_core_assert.svh
// assertion macros used by the checker file of the packet deframer
`ifndef RSP_PACKET_DEFRAMER_RX_CORE_ASSERT_SVH
`define RSP_PACKET_DEFRAMER_RX_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RSPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RSPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rspd_pkg.sv
// shared types and constants of the packet deframer
package rspd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  localparam logic [BYTE_W-1:0] START_CHAR = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] CSUM_CHAR  = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] ACK_CHAR   = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] NAK_CHAR   = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] BAD_DIGIT  = 8'hFF;  // non-hex digit reads as -1

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  // byte held in the input register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              end_of_packet;
    logic              checksum_ok;
    logic [BYTE_W-1:0] reply_char;
    logic [BYTE_W-1:0] computed_sum;
    logic [BYTE_W-1:0] received_sum;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

  // result offered by the framer to the output register
  typedef struct packed {
    logic    valid;
    result_t data;
  } res_push_t;

endpackage

// File: src/rspd_if.sv
// valid/ready channel interfaces for received bytes and results
interface rspd_in_if;
  logic                      valid;
  logic                      ready;
  logic [rspd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rspd_out_if;
  logic                        valid;
  logic                        ready;
  logic [rspd_pkg::BYTE_W-1:0] payload_byte;
  logic                        end_of_packet;
  logic                        checksum_ok;
  logic [rspd_pkg::BYTE_W-1:0] reply_char;
  logic [rspd_pkg::BYTE_W-1:0] computed_sum;
  logic [rspd_pkg::BYTE_W-1:0] received_sum;
  logic [rspd_pkg::LEN_W-1:0]  payload_length;

  modport source (
    output valid, output payload_byte, output end_of_packet, output checksum_ok,
    output reply_char, output computed_sum, output received_sum,
    output payload_length, input ready
  );
  modport sink (
    input valid, input payload_byte, input end_of_packet, input checksum_ok,
    input reply_char, input computed_sum, input received_sum,
    input payload_length, output ready
  );
endinterface

// File: src/rsp_packet_deframer_rx_core.sv
// top level of the remote serial protocol packet deframer, receive side
// an input transfer is held in the input register before the framer offers its result
// throughput: one byte per cycle, set by the single framer step per cycle
// a body byte or a low checksum digit waits only while the result register is full and stalled
// reset (synchronous, rst_n low) empties both registers and returns to hunting with zero sums
module rsp_packet_deframer_rx_core (
  input  logic        clk,
  input  logic        rst_n,
  rspd_in_if.sink     in_ch,
  rspd_out_if.source  out_ch
);

  rspd_pkg::in_item_t  item;     // byte waiting in the input register
  rspd_pkg::res_push_t res;      // result offered to the output register
  logic                advance;  // framer consumes the held byte this cycle
  logic                can_load; // result register free or being drained

  // input register, refilled in the same cycle it is consumed
  rspd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .item    (item)
  );

  // hunt / body / checksum digit sequencing and the end-of-packet compare
  rspd_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .can_load (can_load),
    .advance  (advance),
    .res      (res)
  );

  // result register toward downstream
  rspd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

// File: src/rspd_in_stage.sv
// input register: holds one received byte until the framer consumes it
module rspd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  rspd_in_if.sink            in_ch,
  input  logic               advance,
  output rspd_pkg::in_item_t item
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [rspd_pkg::BYTE_W-1:0] byte_r;
  logic                        accept;

  assign in_ch.ready = !valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

// File: src/rspd_framer.sv
// framing state machine, running sum, byte count and checksum decode
module rspd_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  rspd_pkg::in_item_t  item,
  input  logic                can_load,
  output logic                advance,
  output rspd_pkg::res_push_t res
);

  rspd_pkg::phase_t            phase_r;
  rspd_pkg::phase_t            phase_nxt;
  logic [rspd_pkg::BYTE_W-1:0] sum_r;
  logic [rspd_pkg::BYTE_W-1:0] sum_nxt;
  logic [rspd_pkg::BYTE_W-1:0] hi_part_r;
  logic [rspd_pkg::BYTE_W-1:0] hi_part_nxt;
  logic [rspd_pkg::LEN_W-1:0]  count_r;
  logic [rspd_pkg::LEN_W-1:0]  count_nxt;
  logic [rspd_pkg::BYTE_W-1:0] digit;
  logic [rspd_pkg::BYTE_W-1:0] rx_sum;
  logic                        needs_res;

  function automatic logic [rspd_pkg::BYTE_W-1:0] hex_value(
    input logic [rspd_pkg::BYTE_W-1:0] c
  );
    logic [rspd_pkg::BYTE_W-1:0] v;
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = rspd_pkg::BAD_DIGIT;
    end
    return v;
  endfunction

  assign digit  = hex_value(item.rx_byte);
  assign rx_sum = hi_part_r + digit;

  // body bytes other than '#' and the low digit produce a result
  assign needs_res = (phase_r == rspd_pkg::PH_LOW) ||
                     (phase_r == rspd_pkg::PH_BODY && item.rx_byte != rspd_pkg::CSUM_CHAR);
  assign advance   = item.valid && (!needs_res || can_load);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      unique case (phase_r)
        rspd_pkg::PH_HUNT: begin
          if (item.rx_byte == rspd_pkg::START_CHAR) begin
            phase_nxt = rspd_pkg::PH_BODY;
          end
        end
        rspd_pkg::PH_BODY: begin
          if (item.rx_byte == rspd_pkg::CSUM_CHAR) begin
            phase_nxt = rspd_pkg::PH_HIGH;
          end
        end
        rspd_pkg::PH_HIGH: phase_nxt = rspd_pkg::PH_LOW;
        rspd_pkg::PH_LOW:  phase_nxt = rspd_pkg::PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    sum_nxt     = sum_r;
    hi_part_nxt = hi_part_r;
    count_nxt   = count_r;
    res         = '0;
    if (advance) begin
      unique case (phase_r)
        rspd_pkg::PH_HUNT: begin
          if (item.rx_byte == rspd_pkg::START_CHAR) begin
            sum_nxt     = '0;
            hi_part_nxt = '0;
            count_nxt   = '0;
          end
        end
        rspd_pkg::PH_BODY: begin
          if (item.rx_byte != rspd_pkg::CSUM_CHAR) begin
            sum_nxt = sum_r + item.rx_byte;
            if (count_r != rspd_pkg::LEN_MAX) begin
              count_nxt = count_r + 1'b1;
            end
            res.valid             = 1'b1;
            res.data.payload_byte = item.rx_byte;
          end
        end
        rspd_pkg::PH_HIGH: begin
          hi_part_nxt = {digit[3:0], 4'h0};
        end
        rspd_pkg::PH_LOW: begin
          res.valid               = 1'b1;
          res.data.end_of_packet  = 1'b1;
          res.data.checksum_ok    = (rx_sum == sum_r);
          res.data.reply_char     = (rx_sum == sum_r) ? rspd_pkg::ACK_CHAR
                                                      : rspd_pkg::NAK_CHAR;
          res.data.computed_sum   = sum_r;
          res.data.received_sum   = rx_sum;
          res.data.payload_length = count_r;
          sum_nxt                 = '0;
          hi_part_nxt             = '0;
          count_nxt               = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rspd_pkg::PH_HUNT;
      sum_r     <= '0;
      hi_part_r <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      hi_part_r <= hi_part_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// File: src/rspd_out_stage.sv
// result register: holds one result until the downstream side takes it
module rspd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  rspd_pkg::res_push_t res,
  output logic                can_load,
  rspd_out_if.source          out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  rspd_pkg::result_t data_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= res.data;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.payload_byte   = data_r.payload_byte;
  assign out_ch.end_of_packet  = data_r.end_of_packet;
  assign out_ch.checksum_ok    = data_r.checksum_ok;
  assign out_ch.reply_char     = data_r.reply_char;
  assign out_ch.computed_sum   = data_r.computed_sum;
  assign out_ch.received_sum   = data_r.received_sum;
  assign out_ch.payload_length = data_r.payload_length;

endmodule

// File: src/rspd_checker.sv
// port-level checks of the packet deframer, bound to the top level
`include "rsp_packet_deframer_rx_core_assert.svh"

module rspd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rspd_pkg::BYTE_W-1:0] payload_byte,
  input logic                        end_of_packet,
  input logic                        checksum_ok,
  input logic [rspd_pkg::BYTE_W-1:0] reply_char,
  input logic [rspd_pkg::BYTE_W-1:0] computed_sum,
  input logic [rspd_pkg::BYTE_W-1:0] received_sum,
  input logic [rspd_pkg::LEN_W-1:0]  payload_length
);

  `RSPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(payload_byte) && $stable(end_of_packet) && $stable(reply_char) && $stable(payload_length), "stalled result changed")
  `RSPD_ASSERT_SAME(a_end_zero_byte, clk, rst_n, out_valid && end_of_packet, payload_byte == '0, "end result carries a payload byte")
  `RSPD_ASSERT_SAME(a_payload_clean, clk, rst_n, out_valid && !end_of_packet, !checksum_ok && reply_char == '0 && computed_sum == '0 && received_sum == '0 && payload_length == '0, "payload result has end fields set")
  `RSPD_ASSERT_SAME(a_ok_matches, clk, rst_n, out_valid && end_of_packet, checksum_ok == (computed_sum == received_sum), "checksum flag disagrees with sums")
  `RSPD_ASSERT_SAME(a_reply_char, clk, rst_n, out_valid && end_of_packet, (checksum_ok && reply_char == rspd_pkg::ACK_CHAR) || (!checksum_ok && reply_char == rspd_pkg::NAK_CHAR), "reply character disagrees with flag")

endmodule

bind rsp_packet_deframer_rx_core rspd_checker u_rspd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .payload_byte   (out_ch.payload_byte),
  .end_of_packet  (out_ch.end_of_packet),
  .checksum_ok    (out_ch.checksum_ok),
  .reply_char     (out_ch.reply_char),
  .computed_sum   (out_ch.computed_sum),
  .received_sum   (out_ch.received_sum),
  .payload_length (out_ch.payload_length)
);
